// ===== sv/detection_box_decode_defines.svh =====
// Assertion helpers for the detection box decoder top level.
// Both macros sample on the rising edge of the clock and stay quiet while
// the active-low reset is asserted.
`ifndef DETECTION_BOX_DECODE_DEFINES_SVH
`define DETECTION_BOX_DECODE_DEFINES_SVH

// Same-cycle implication.
`define DBD_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("detection box decode: same-cycle check failed");

// Next-cycle implication.
`define DBD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("detection box decode: next-cycle check failed");

`endif

// ===== sv/dbd_pkg.sv =====
`default_nettype none

package dbd_pkg;

    localparam int VALUE_BITS_DEF     = 32;
    localparam int MAX_BOX_LENGTH_DEF = 256;

    localparam int FRAC_BITS       = 16;
    localparam int OBJ_BOX_LENGTH  = 85;
    localparam int COORD_COUNT     = 4;
    localparam int OBJ_CLASS_START = 5;
    localparam int MIN_BOX_LENGTH  = 5;
    localparam int CLASS_BITS      = 8;

    localparam int THR_BITS      = 17;
    localparam int LEN_BITS      = 9;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [THR_BITS-1:0] THR_RESET = 17'd16384;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 9'd84;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SCORE_THRESHOLD = 1'b0,
        REG_BOX_LENGTH      = 1'b1
    } t_cfg_reg;

    // Control of one finished box record handed to the scoring stages
    typedef struct packed {
        logic valid;
        logic obj_mode;
    } t_rec_ctl;

endpackage

`default_nettype wire

// ===== sv/dbd_accum.sv =====
`default_nettype none

module dbd_accum #(
    parameter int VALUE_BITS     = dbd_pkg::VALUE_BITS_DEF,
    parameter int MAX_BOX_LENGTH = dbd_pkg::MAX_BOX_LENGTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [dbd_pkg::LEN_BITS-1:0]        i_box_length,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [VALUE_BITS-1:0]        i_value,
    input  wire logic                                i_rec_take,
    output dbd_pkg::t_rec_ctl                        o_rec_ctl,
    output logic signed [VALUE_BITS-1:0]             o_cx,
    output logic signed [VALUE_BITS-1:0]             o_cy,
    output logic signed [VALUE_BITS-1:0]             o_w,
    output logic signed [VALUE_BITS-1:0]             o_h,
    output logic signed [((VALUE_BITS > dbd_pkg::FRAC_BITS + 1) ? VALUE_BITS
                          : dbd_pkg::FRAC_BITS + 2)-1:0] o_obj,
    output logic signed [VALUE_BITS-1:0]             o_best,
    output logic [dbd_pkg::CLASS_BITS-1:0]           o_class
);

    localparam int WideW = (VALUE_BITS > dbd_pkg::FRAC_BITS + 1) ? VALUE_BITS
                           : dbd_pkg::FRAC_BITS + 2;
    localparam int PosW  = $clog2(MAX_BOX_LENGTH);
    localparam int LenNeed = $clog2(MAX_BOX_LENGTH + 1);
    localparam int LenW  = (LenNeed > dbd_pkg::LEN_BITS) ? LenNeed : dbd_pkg::LEN_BITS;
    localparam logic signed [WideW-1:0] OBJ_ONE = WideW'(1) << dbd_pkg::FRAC_BITS;

    logic [PosW-1:0]               r_pos;
    logic signed [VALUE_BITS-1:0]  r_cx, r_cy, r_w, r_h, r_best;
    logic signed [WideW-1:0]       r_obj;
    logic [dbd_pkg::CLASS_BITS-1:0] r_class;

    logic signed [VALUE_BITS-1:0]  n_cx, n_cy, n_w, n_h, n_best;
    logic signed [WideW-1:0]       n_obj;
    logic [dbd_pkg::CLASS_BITS-1:0] n_class;

    dbd_pkg::t_rec_ctl             r_rec_ctl;
    logic                          n_rec_valid;
    logic signed [VALUE_BITS-1:0]  r_rec_cx, r_rec_cy, r_rec_w, r_rec_h, r_rec_best;
    logic signed [WideW-1:0]       r_rec_obj;
    logic [dbd_pkg::CLASS_BITS-1:0] r_rec_class;

    logic [LenW-1:0] len_raw;
    logic [LenW-1:0] len_eff;
    logic            obj_mode;
    logic [PosW-1:0] first_cls_pos;
    logic [PosW-1:0] class_off;
    logic [LenW:0]   pos_inc;
    logic            box_end;
    logic            accept;

    // Clamp the box length into the supported range
    always_comb begin
        len_raw = LenW'(i_box_length);
        if (len_raw < LenW'(dbd_pkg::MIN_BOX_LENGTH)) begin
            len_eff = LenW'(dbd_pkg::MIN_BOX_LENGTH);
        end else if (len_raw > LenW'(MAX_BOX_LENGTH)) begin
            len_eff = LenW'(MAX_BOX_LENGTH);
        end else begin
            len_eff = len_raw;
        end
    end

    assign obj_mode      = (len_eff == LenW'(dbd_pkg::OBJ_BOX_LENGTH));
    assign first_cls_pos = obj_mode ? PosW'(dbd_pkg::OBJ_CLASS_START)
                                    : PosW'(dbd_pkg::COORD_COUNT);
    assign class_off     = r_pos - first_cls_pos;
    assign pos_inc       = (LenW + 1)'(r_pos) + (LenW + 1)'(1);
    assign box_end       = (pos_inc >= {1'b0, len_eff});

    assign o_ready = !r_rec_ctl.valid || i_rec_take;
    assign accept  = i_valid && o_ready;

    // Record slot: empty on take, filled when a box ends
    always_comb begin
        n_rec_valid = r_rec_ctl.valid;
        if (i_rec_take) begin
            n_rec_valid = 1'b0;
        end
        if (accept && box_end) begin
            n_rec_valid = 1'b1;
        end
    end

    always_comb begin
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_w     = r_w;
        n_h     = r_h;
        n_obj   = r_obj;
        n_best  = r_best;
        n_class = r_class;
        if (r_pos == PosW'(0)) begin
            n_cx = i_value;
        end else if (r_pos == PosW'(1)) begin
            n_cy = i_value;
        end else if (r_pos == PosW'(2)) begin
            n_w = i_value;
        end else if (r_pos == PosW'(3)) begin
            n_h = i_value;
        end else if (obj_mode && r_pos == PosW'(dbd_pkg::COORD_COUNT)) begin
            n_obj = WideW'(i_value);
        end else if (r_pos == first_cls_pos) begin
            n_best  = i_value;
            n_class = '0;
        end else if (r_pos > first_cls_pos && i_value > r_best) begin
            n_best  = i_value;
            n_class = dbd_pkg::CLASS_BITS'(class_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_cx          <= '0;
            r_cy          <= '0;
            r_w           <= '0;
            r_h           <= '0;
            r_obj         <= OBJ_ONE;
            r_best        <= '0;
            r_class       <= '0;
            r_rec_ctl     <= '0;
        end else begin
            r_rec_ctl.valid <= n_rec_valid;
            if (accept) begin
                r_cx <= n_cx;
                r_cy <= n_cy;
                r_w  <= n_w;
                r_h  <= n_h;
                if (box_end) begin
                    // Restart the argmax for the next box
                    r_pos              <= '0;
                    r_obj              <= OBJ_ONE;
                    r_best             <= '0;
                    r_class            <= '0;
                    r_rec_ctl.obj_mode <= obj_mode;
                end else begin
                    r_pos   <= r_pos + PosW'(1);
                    r_obj   <= n_obj;
                    r_best  <= n_best;
                    r_class <= n_class;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && box_end) begin
            r_rec_cx    <= n_cx;
            r_rec_cy    <= n_cy;
            r_rec_w     <= n_w;
            r_rec_h     <= n_h;
            r_rec_obj   <= n_obj;
            r_rec_best  <= n_best;
            r_rec_class <= n_class;
        end
    end

    assign o_rec_ctl = r_rec_ctl;
    assign o_cx      = r_rec_cx;
    assign o_cy      = r_rec_cy;
    assign o_w       = r_rec_w;
    assign o_h       = r_rec_h;
    assign o_obj     = r_rec_obj;
    assign o_best    = r_rec_best;
    assign o_class   = r_rec_class;

endmodule

`default_nettype wire

// ===== sv/detection_box_decode.sv =====
// Detection box decoder: streams the values of candidate boxes (cx, cy, w, h,
// optional objectness, class scores) one beat each on the s_axis channel and
// returns one beat on m_axis for each box whose score (and objectness, if
// present) meets the threshold: corner x/y, w, h, score, best class index.
// Configuration (score threshold, box length) is written on the cfg channel,
// which is always ready; write it only while no box is in flight.
// Throughput: one input beat per cycle; the box accumulator takes a new beat
// every cycle as long as its finished-box record can move on.
// The last beat of a box reaches o_m_axis_tvalid through the box record,
// which loads at the accepting edge, then the product register and the
// output register; the objectness times score multiplier has a stage of
// its own.
// Reset: synchronous, active low; clears the registers to threshold 0.25,
// box length 84, and restarts the running argmax and position.
// Stall: the output register holds its beat while i_m_axis_tready is low; the
// product stage and the box record fill behind it, and only then does
// o_s_axis_tready drop, so input beats keep flowing through a stalled output.
`default_nettype none

`include "detection_box_decode_defines.svh"

module detection_box_decode #(
    parameter int VALUE_BITS     = dbd_pkg::VALUE_BITS_DEF,
    parameter int MAX_BOX_LENGTH = dbd_pkg::MAX_BOX_LENGTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dbd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [dbd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // input stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: element_value
    input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,
    // output stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata: corner_x, corner_y, box_width, box_height, conf_score, class_index
    output logic [((5 * VALUE_BITS + dbd_pkg::CLASS_BITS + 7) / 8) * 8-1:0]
                                                     o_m_axis_tdata
);

    localparam int OutW  = ((5 * VALUE_BITS + dbd_pkg::CLASS_BITS + 7) / 8) * 8;
    localparam int WideW = (VALUE_BITS > dbd_pkg::FRAC_BITS + 1) ? VALUE_BITS
                           : dbd_pkg::FRAC_BITS + 2;
    localparam int ProdW = WideW + VALUE_BITS;
    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Configuration registers
    logic [dbd_pkg::THR_BITS-1:0] r_thr;
    logic [dbd_pkg::LEN_BITS-1:0] r_len;
    logic signed [WideW-1:0]      thr_wide;

    assign o_cfg_ready = 1'b1;
    assign thr_wide    = $signed(WideW'(r_thr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= dbd_pkg::THR_RESET;
            r_len <= dbd_pkg::LEN_RESET;
        end else if (i_cfg_valid) begin
            case (dbd_pkg::t_cfg_reg'(i_cfg_index))
                dbd_pkg::REG_SCORE_THRESHOLD: r_thr <= i_cfg_data[dbd_pkg::THR_BITS-1:0];
                dbd_pkg::REG_BOX_LENGTH:      r_len <= i_cfg_data[dbd_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Box accumulator: coordinate holds and running argmax
    dbd_pkg::t_rec_ctl             rec_ctl;
    logic signed [VALUE_BITS-1:0]  rec_cx, rec_cy, rec_w, rec_h, rec_best;
    logic signed [WideW-1:0]       rec_obj;
    logic [dbd_pkg::CLASS_BITS-1:0] rec_class;
    logic                          b_adv;
    logic                          p_adv;

    dbd_accum #(
        .VALUE_BITS     (VALUE_BITS),
        .MAX_BOX_LENGTH (MAX_BOX_LENGTH)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_box_length (r_len),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_value      ($signed(i_s_axis_tdata[VALUE_BITS-1:0])),
        .i_rec_take   (b_adv),
        .o_rec_ctl    (rec_ctl),
        .o_cx         (rec_cx),
        .o_cy         (rec_cy),
        .o_w          (rec_w),
        .o_h          (rec_h),
        .o_obj        (rec_obj),
        .o_best       (rec_best),
        .o_class      (rec_class)
    );

    // Product stage: objectness times best score, corner differences
    dbd_pkg::t_rec_ctl             r_p_ctl;
    logic signed [ProdW-1:0]       r_p_prod;
    logic                          r_p_obj_ok;
    logic signed [VALUE_BITS:0]    r_p_cx_d, r_p_cy_d;
    logic signed [VALUE_BITS-1:0]  r_p_w, r_p_h, r_p_best;
    logic [dbd_pkg::CLASS_BITS-1:0] r_p_class;

    assign b_adv = !r_p_ctl.valid || p_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else if (b_adv) begin
            r_p_ctl <= rec_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_p_prod   <= ProdW'(rec_obj) * ProdW'(rec_best);
            r_p_obj_ok <= (rec_obj >= thr_wide);
            r_p_cx_d   <= (VALUE_BITS + 1)'(rec_cx) - (VALUE_BITS + 1)'(rec_w >>> 1);
            r_p_cy_d   <= (VALUE_BITS + 1)'(rec_cy) - (VALUE_BITS + 1)'(rec_h >>> 1);
            r_p_w      <= rec_w;
            r_p_h      <= rec_h;
            r_p_best   <= rec_best;
            r_p_class  <= rec_class;
        end
    end

    // Output stage: saturate, threshold, register the result beat
    logic signed [ProdW-1:0]      prod_sh;
    logic                         prod_fits;
    logic signed [VALUE_BITS-1:0] score;
    logic signed [VALUE_BITS-1:0] corner_x, corner_y;
    logic                         keep;

    assign prod_sh   = r_p_prod >>> dbd_pkg::FRAC_BITS;
    assign prod_fits = (&prod_sh[ProdW-1:VALUE_BITS-1]) || !(|prod_sh[ProdW-1:VALUE_BITS-1]);

    always_comb begin
        if (!r_p_ctl.obj_mode) begin
            score = r_p_best;
        end else if (prod_fits) begin
            score = prod_sh[VALUE_BITS-1:0];
        end else begin
            score = prod_sh[ProdW-1] ? VMIN : VMAX;
        end
        if (r_p_cx_d[VALUE_BITS] == r_p_cx_d[VALUE_BITS-1]) begin
            corner_x = r_p_cx_d[VALUE_BITS-1:0];
        end else begin
            corner_x = r_p_cx_d[VALUE_BITS] ? VMIN : VMAX;
        end
        if (r_p_cy_d[VALUE_BITS] == r_p_cy_d[VALUE_BITS-1]) begin
            corner_y = r_p_cy_d[VALUE_BITS-1:0];
        end else begin
            corner_y = r_p_cy_d[VALUE_BITS] ? VMIN : VMAX;
        end
    end

    // Drop the box on a low score, or on low objectness in objectness mode
    assign keep = r_p_ctl.valid && (WideW'(score) >= thr_wide)
                  && (!r_p_ctl.obj_mode || r_p_obj_ok);

    logic                           r_o_valid;
    logic signed [VALUE_BITS-1:0]   r_o_cx, r_o_cy, r_o_w, r_o_h, r_o_score;
    logic [dbd_pkg::CLASS_BITS-1:0] r_o_class;

    assign p_adv = !r_o_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_adv) begin
            r_o_valid <= keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_o_cx    <= corner_x;
            r_o_cy    <= corner_y;
            r_o_w     <= r_p_w;
            r_o_h     <= r_p_h;
            r_o_score <= score;
            r_o_class <= r_p_class;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = OutW'({r_o_class, r_o_score, r_o_h, r_o_w, r_o_cy, r_o_cx});

    // Input ready only drops while a finished box record is stuck
    `DBD_ASSERT_IMPLY(a_ready_drop, i_clk, i_rst_n, !o_s_axis_tready, rec_ctl.valid && !b_adv)
    // A moving box record lands in the product stage
    `DBD_ASSERT_NEXT(a_rec_moves, i_clk, i_rst_n, rec_ctl.valid && b_adv, r_p_ctl.valid)
    // A taken result with nothing behind it leaves the output empty
    `DBD_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n,
        r_o_valid && i_m_axis_tready && !r_p_ctl.valid, !o_m_axis_tvalid)
    // Low objectness never produces a result beat
    `DBD_ASSERT_NEXT(a_obj_drop, i_clk, i_rst_n,
        r_p_ctl.valid && r_p_ctl.obj_mode && !r_p_obj_ok && p_adv, !r_o_valid)

endmodule

`default_nettype wire
